// ----- rtl/nfba_pkg.sv -----
// nfba_pkg: shared constants and types for the next-fit block allocator
// used by nfba_engine and next_fit_block_allocator_top; no dependencies
`default_nettype none

package nfba_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int CFG_W      = 5;
  localparam int CMP_W      = 32;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CFG_W-1:0]     cfg_t;
  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [CMP_W-1:0]     cmp_t;

  typedef struct packed {
    logic  operation;
    idx_t  block_slot;
    size_t amount;
  } item_t;

  typedef struct packed {
    logic  granted;
    idx_t  granted_block;
    size_t remaining_size;
    cmp_t  total_compares;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/nfba_engine.sv -----
// nfba_engine: size table memory, rover, compare counter and scan sequencer
// depends on nfba_pkg
`default_nettype none

module nfba_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nfba_pkg::cfg_t   active_i,
  input  logic             item_valid_i,
  input  nfba_pkg::item_t  item_i,
  output logic             idle_o,
  input  logic             res_take_i,
  output logic             res_valid_o,
  output nfba_pkg::result_t res_o
);
  import nfba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e  state_q, state_d;
  idx_t    rover_q, rover_d;
  cmp_t    cmp_q, cmp_d;
  idx_t    pos_q, pos_d;
  cnt_t    k_q, k_d;
  cnt_t    n_q, n_d;
  size_t   amt_q, amt_d;
  result_t res_q, res_d;

  size_t   mem_q [MAX_BLOCKS];
  size_t   rd_q;
  idx_t    rd_addr;
  logic    wr_en;
  idx_t    wr_addr;
  size_t   wr_data;

  cnt_t    n_cur;
  idx_t    start_pos;
  cnt_t    pos_inc;
  idx_t    nxt_pos;
  logic    fits;
  size_t   left;

  always_comb begin
    if (active_i == '0) begin
      n_cur = CNT_W'(1);
    end else if (CNT_W'(active_i) > CNT_W'(MAX_BLOCKS)) begin
      n_cur = CNT_W'(MAX_BLOCKS);
    end else begin
      n_cur = CNT_W'(active_i);
    end
  end

  assign start_pos = (CNT_W'(rover_q) < n_cur) ? rover_q : '0;
  assign pos_inc   = CNT_W'(pos_q) + CNT_W'(1);
  assign nxt_pos   = (pos_inc < n_q) ? pos_inc[IDX_W-1:0] : '0;
  assign fits      = (amt_q <= rd_q);
  assign left      = rd_q - amt_q;

  always_comb begin
    state_d = state_q;
    rover_d = rover_q;
    cmp_d   = cmp_q;
    pos_d   = pos_q;
    k_d     = k_q;
    n_d     = n_q;
    amt_d   = amt_q;
    res_d   = res_q;
    rd_addr = pos_q;
    wr_en   = 1'b0;
    wr_addr = item_i.block_slot;
    wr_data = item_i.amount;
    case (state_q)
      S_IDLE: begin
        rd_addr = start_pos;
        if (item_valid_i) begin
          if (item_i.operation == OP_LOAD) begin
            wr_en   = 1'b1;
            res_d   = '{granted: 1'b1, granted_block: item_i.block_slot,
                        remaining_size: item_i.amount, total_compares: cmp_q};
            state_d = S_DONE;
          end else begin
            pos_d   = start_pos;
            n_d     = n_cur;
            k_d     = CNT_W'(1);
            amt_d   = item_i.amount;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_addr = nxt_pos;
        cmp_d   = cmp_q + CMP_W'(1);
        if (fits) begin
          wr_en   = 1'b1;
          wr_addr = pos_q;
          wr_data = left;
          rover_d = pos_q;
          res_d   = '{granted: 1'b1, granted_block: pos_q,
                      remaining_size: left, total_compares: cmp_d};
          state_d = S_DONE;
        end else if (k_q == n_q) begin
          res_d   = '{granted: 1'b0, granted_block: '0,
                      remaining_size: '0, total_compares: cmp_d};
          state_d = S_DONE;
        end else begin
          pos_d = nxt_pos;
          k_d   = k_q + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rover_q <= '0;
      cmp_q   <= '0;
    end else begin
      state_q <= state_d;
      rover_q <= rover_d;
      cmp_q   <= cmp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    k_q   <= k_d;
    n_q   <= n_d;
    amt_q <= amt_d;
    res_q <= res_d;
  end

  // size table, one read and one write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ----- rtl/next_fit_block_allocator_top.sv -----
// next_fit_block_allocator_top: config register, input handshake, output register
// depends on nfba_pkg and nfba_engine
//
//   channel   direction  handshake                    payload
//   input     in         in_valid_i / in_stall_o      operation, block_slot, amount
//   output    out        out_valid_o / out_stall_i    granted, granted_block,
//                                                     remaining_size, total_compares
//   config    in         cfg_we_i                     cfg_wdata_i (active_blocks)
//
// a load writes one table entry; an allocation examines k blocks, where k is 1 to
// active_blocks (0 counts as 1, above 16 as 16), one table read per cycle
// through the single read port of the size table
// reset clears the rover, the compare count and the output valid; active_blocks
// resets to 16; table contents are undefined until loaded
// a new transaction is taken while a finished result waits in the output register
`default_nettype none

module next_fit_block_allocator_top (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  nfba_pkg::cfg_t          cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    operation_i,
  input  nfba_pkg::idx_t          block_slot_i,
  input  nfba_pkg::size_t         amount_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    granted_o,
  output nfba_pkg::idx_t          granted_block_o,
  output nfba_pkg::size_t         remaining_size_o,
  output nfba_pkg::cmp_t          total_compares_o
);
  import nfba_pkg::*;

  cfg_t    active_q;
  logic    out_valid_q;
  result_t out_q;

  logic    eng_idle;
  logic    eng_res_valid;
  result_t eng_res;
  logic    res_take;
  item_t   item;

  assign item = '{operation: operation_i, block_slot: block_slot_i, amount: amount_i};

  assign res_take = eng_res_valid && (!out_valid_q || !out_stall_i);

  nfba_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .active_i     (active_q),
    .item_valid_i (in_valid_i),
    .item_i       (item),
    .idle_o       (eng_idle),
    .res_take_i   (res_take),
    .res_valid_o  (eng_res_valid),
    .res_o        (eng_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= CFG_W'(MAX_BLOCKS);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (res_take) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= eng_res;
    end
  end

  assign in_stall_o       = !eng_idle;
  assign out_valid_o      = out_valid_q;
  assign granted_o        = out_q.granted;
  assign granted_block_o  = out_q.granted_block;
  assign remaining_size_o = out_q.remaining_size;
  assign total_compares_o = out_q.total_compares;

endmodule

`default_nettype wire

// ----- test/tb_next_fit_block_allocator_top.sv -----
// testbench for next_fit_block_allocator_top: random and directed load and allocate
// transactions checked against a next-fit scoreboard; depends on nfba_pkg and the rtl
`default_nettype none

class alloc_scoreboard;
  nfba_pkg::size_t   block_size [nfba_pkg::MAX_BLOCKS];
  nfba_pkg::idx_t    rover;
  nfba_pkg::cmp_t    compare_count;
  nfba_pkg::cfg_t    active_blocks;
  nfba_pkg::result_t expected_q [$];
  int                failures;

  function new();
    rover         = '0;
    compare_count = '0;
    active_blocks = nfba_pkg::cfg_t'(nfba_pkg::MAX_BLOCKS);
    failures      = 0;
    foreach (block_size[i]) block_size[i] = '0;
  endfunction

  function void set_active(nfba_pkg::cfg_t value);
    active_blocks = value;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void note_item(logic op, nfba_pkg::idx_t slot, nfba_pkg::size_t amount);
    nfba_pkg::result_t res;
    int                n;
    int                pos;
    bit                found;
    res = '0;
    if (op == nfba_pkg::OP_LOAD) begin
      block_size[slot]   = amount;
      res.granted        = 1'b1;
      res.granted_block  = slot;
      res.remaining_size = amount;
    end else begin
      n = (active_blocks == 0) ? 1 :
          (active_blocks > nfba_pkg::MAX_BLOCKS) ? nfba_pkg::MAX_BLOCKS : int'(active_blocks);
      pos   = (int'(rover) < n) ? int'(rover) : 0;
      found = 1'b0;
      for (int k = 0; k < n && !found; k++) begin
        compare_count++;
        if (amount <= block_size[pos]) begin
          block_size[pos]    = block_size[pos] - amount;
          rover              = nfba_pkg::idx_t'(pos);
          found              = 1'b1;
          res.granted        = 1'b1;
          res.granted_block  = nfba_pkg::idx_t'(pos);
          res.remaining_size = block_size[pos];
        end else begin
          pos = (pos + 1 < n) ? pos + 1 : 0;
        end
      end
    end
    res.total_compares = compare_count;
    expected_q = {expected_q, res};
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  function void check_result(nfba_pkg::result_t got);
    nfba_pkg::result_t want;
    if (expected_q.size() == 0) begin
      failures++;
      $display("%0t: result expected none actual %0h", $time, got);
      return;
    end
    want = expected_q.pop_front();
    compare_field("granted", 32'(want.granted), 32'(got.granted));
    compare_field("granted_block", 32'(want.granted_block), 32'(got.granted_block));
    compare_field("remaining_size", 32'(want.remaining_size), 32'(got.remaining_size));
    compare_field("total_compares", want.total_compares, got.total_compares);
  endfunction
endclass

module tb_next_fit_block_allocator_top;
  import nfba_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 160;

  logic  clk_i;
  logic  rst_ni       = 1'b0;
  logic  cfg_we_i     = 1'b0;
  cfg_t  cfg_wdata_i  = '0;
  logic  in_valid_i   = 1'b0;
  logic  in_stall_o;
  logic  operation_i  = OP_LOAD;
  idx_t  block_slot_i = '0;
  size_t amount_i     = '0;
  logic  out_valid_o;
  logic  out_stall_i  = 1'b0;
  logic  granted_o;
  idx_t  granted_block_o;
  size_t remaining_size_o;
  cmp_t  total_compares_o;

  alloc_scoreboard sb;
  int              burst_left = 0;
  int              cycle_count = 0;

  next_fit_block_allocator_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .block_slot_i     (block_slot_i),
    .amount_i         (amount_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .granted_o        (granted_o),
    .granted_block_o  (granted_block_o),
    .remaining_size_o (remaining_size_o),
    .total_compares_o (total_compares_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // receiver stall pattern
  initial begin
    int mode;
    int len;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      len  = (mode == 3) ? $urandom_range(2, 12) : $urandom_range(4, 40);
      repeat (len) begin
        @(posedge clk_i);
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 2) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({granted_o, granted_block_o, remaining_size_o, total_compares_o});
  end

  task automatic push_item(logic op, idx_t slot, size_t amount);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    block_slot_i <= slot;
    amount_i     <= amount;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(op, slot, amount);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_active(cfg_t value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_active(value);
  endtask

  function automatic size_t pick_request();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return size_t'($urandom_range(0, 255));
      6, 7:             return size_t'($urandom_range(0, 4095));
      default:          return size_t'($urandom());
    endcase
  endfunction

  function automatic size_t pick_block_size();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return size_t'($urandom());
      5, 6, 7:       return size_t'($urandom_range(16384, 65535));
      8:             return '0;
      default:       return '1;
    endcase
  endfunction

  initial begin
    cfg_t phase_cfg [PHASES];
    size_t amount;
    sb = new();
    phase_cfg = '{5'd4, 5'd1, 5'd0, 5'd31, 5'd17, 5'd16, 5'd0, 5'd0, 5'd0, 5'd0};
    for (int p = 6; p < PHASES; p++) phase_cfg[p] = cfg_t'($urandom_range(0, 31));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // every block loaded before any allocation can read it
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      amount = (i == 0) ? size_t'(0) : (i == 1) ? size_t'(65535) : (i == 2) ? size_t'(1) :
               (i == 15) ? size_t'(40000) : size_t'(100 * i);
      push_item(OP_LOAD, idx_t'(i), amount);
    end
    push_item(OP_ALLOC, '0, size_t'(0));
    push_item(OP_ALLOC, '0, size_t'(65535));
    push_item(OP_ALLOC, '0, size_t'(65535));
    push_item(OP_ALLOC, '0, size_t'(1));
    push_item(OP_ALLOC, '0, size_t'(1200));
    push_item(OP_ALLOC, '0, size_t'(40000));
    push_item(OP_ALLOC, '0, size_t'(500));
    push_item(OP_ALLOC, '0, size_t'(0));
    push_item(OP_LOAD, idx_t'(13), size_t'(65535));
    push_item(OP_ALLOC, '0, size_t'(65535));

    // rover left beyond the active range by the first phase change
    for (int p = 0; p < PHASES; p++) begin
      write_active(phase_cfg[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 35)
          push_item(OP_LOAD, idx_t'($urandom_range(0, MAX_BLOCKS - 1)), pick_block_size());
        else
          push_item(OP_ALLOC, idx_t'($urandom_range(0, MAX_BLOCKS - 1)), pick_request());
      end
    end

    settle();
    if (sb.failures == 0 && sb.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/nfba_pkg.sv
rtl/nfba_engine.sv
rtl/next_fit_block_allocator_top.sv
test/tb_next_fit_block_allocator_top.sv
